// ===== src/rrc_pkg.sv =====
// Shared constants and the arctangent table for the rotated rectangle corner block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package rrc_pkg;

   // CORDIC datapath: x/y in Q2.30 with two guard bits, angle residual in 2^32-per-turn units
   localparam int XY_BITS = 34;
   localparam int XY_FRAC = 30;
   localparam int Z_BITS  = 32;
   localparam int MAX_CORDIC_STAGES = 24;

   // Gain-compensation constant K in Q2.30
   localparam logic signed [XY_BITS-1:0] CORDIC_K = XY_BITS'(34'sh0_26DD_3B6A);

   // Quadrant codes taken from the top two angle bits
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // atan(2^-i) in 2^32-per-turn units
   function automatic logic signed [Z_BITS-1:0] rrc_atan(input int unsigned idx);
      logic signed [Z_BITS-1:0] val;
      case (idx)
         0:       val = 32'sh2000_0000;
         1:       val = 32'sh12E4_051D;
         2:       val = 32'sh09FB_385B;
         3:       val = 32'sh0511_11D4;
         4:       val = 32'sh028B_0D43;
         5:       val = 32'sh0145_D7E1;
         6:       val = 32'sh00A2_F61E;
         7:       val = 32'sh0051_7C55;
         8:       val = 32'sh0028_BE53;
         9:       val = 32'sh0014_5F2E;
         10:      val = 32'sh000A_2F98;
         11:      val = 32'sh0005_17CC;
         12:      val = 32'sh0002_8BE6;
         13:      val = 32'sh0001_45F3;
         14:      val = 32'sh0000_A2F9;
         15:      val = 32'sh0000_517C;
         16:      val = 32'sh0000_28BE;
         17:      val = 32'sh0000_145F;
         18:      val = 32'sh0000_0A2F;
         19:      val = 32'sh0000_0517;
         20:      val = 32'sh0000_028B;
         21:      val = 32'sh0000_0145;
         22:      val = 32'sh0000_00A2;
         23:      val = 32'sh0000_0051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== src/rrc_ifs.sv =====
// Valid/ready channel interfaces for the rectangle request and the corner response.
// Depends on nothing; widths follow the parameters of the instantiating level.
`timescale 1ns / 1ps
`default_nettype none

interface rrc_req_if #(
   parameter int COORD_BITS = 16,
   parameter int ANGLE_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;
   logic        [COORD_BITS-3:0] half_width;
   logic        [COORD_BITS-3:0] half_height;
   logic        [ANGLE_BITS-1:0] angle;

   modport source (output valid, center_x, center_y, half_width, half_height, angle,
                   input ready);
   modport sink   (input valid, center_x, center_y, half_width, half_height, angle,
                   output ready);
endinterface

interface rrc_rsp_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] ne_x;
   logic signed [COORD_BITS-1:0] ne_y;
   logic signed [COORD_BITS-1:0] nw_x;
   logic signed [COORD_BITS-1:0] nw_y;
   logic signed [COORD_BITS-1:0] sw_x;
   logic signed [COORD_BITS-1:0] sw_y;
   logic signed [COORD_BITS-1:0] se_x;
   logic signed [COORD_BITS-1:0] se_y;

   modport source (output valid, ne_x, ne_y, nw_x, nw_y, sw_x, sw_y, se_x, se_y,
                   input ready);
   modport sink   (input valid, ne_x, ne_y, nw_x, nw_y, sw_x, sw_y, se_x, se_y,
                   output ready);
endinterface

`default_nettype wire

// ===== src/rrc_cordic.sv =====
// Unrolled rotation-mode CORDIC, one register per iteration plus a quadrant stage.
// Depends on rrc_pkg for widths, the gain constant and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module rrc_cordic
   import rrc_pkg::*;
#(
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic                      in_valid,
   input  wire logic [ANGLE_BITS-1:0]     angle,
   output logic                           out_valid,
   output logic signed [XY_BITS-1:0]      cos_out,
   output logic signed [XY_BITS-1:0]      sin_out
);

   logic signed [XY_BITS-1:0] x_ff [CORDIC_STAGES];
   logic signed [XY_BITS-1:0] y_ff [CORDIC_STAGES];
   logic signed [Z_BITS-1:0]  z_ff [CORDIC_STAGES];
   logic        [1:0]         q_ff [CORDIC_STAGES];
   logic                      v_ff [CORDIC_STAGES];

   logic signed [XY_BITS-1:0] cos_ff;
   logic signed [XY_BITS-1:0] sin_ff;
   logic                      qv_ff;

   // Split the angle into quadrant and a residual below a quarter turn
   logic        [1:0]         quad0;
   logic signed [Z_BITS-1:0]  z0;

   assign quad0 = angle[ANGLE_BITS-1 -: 2];
   assign z0    = signed'(Z_BITS'(angle[ANGLE_BITS-3:0]) << (Z_BITS - ANGLE_BITS));

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      logic signed [XY_BITS-1:0] x_src, y_src, x_in, y_in;
      logic signed [Z_BITS-1:0]  z_src, z_in;
      logic        [1:0]         q_src;
      logic                      v_src;

      if (i == 0) begin : g_first
         assign x_src = CORDIC_K;
         assign y_src = '0;
         assign z_src = z0;
         assign q_src = quad0;
         assign v_src = in_valid;
      end else begin : g_next
         assign x_src = x_ff[i-1];
         assign y_src = y_ff[i-1];
         assign z_src = z_ff[i-1];
         assign q_src = q_ff[i-1];
         assign v_src = v_ff[i-1];
      end

      // Rotate toward the residual angle
      always_comb begin
         if (!z_src[Z_BITS-1]) begin
            x_in = x_src - (y_src >>> i);
            y_in = y_src + (x_src >>> i);
            z_in = z_src - rrc_atan(i);
         end else begin
            x_in = x_src + (y_src >>> i);
            y_in = y_src - (x_src >>> i);
            z_in = z_src + rrc_atan(i);
         end
      end

      // Hold on stall, advance otherwise
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (advance) begin
            v_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
            q_ff[i] <= q_src;
         end
      end
   end

   // Rotate the first-quadrant result into the requested quadrant
   logic signed [XY_BITS-1:0] cos_in, sin_in;
   logic signed [XY_BITS-1:0] x_last, y_last;

   assign x_last = x_ff[CORDIC_STAGES-1];
   assign y_last = y_ff[CORDIC_STAGES-1];

   always_comb begin
      case (q_ff[CORDIC_STAGES-1])
         QUAD_1: begin
            cos_in = -y_last;
            sin_in = x_last;
         end
         QUAD_2: begin
            cos_in = -x_last;
            sin_in = -y_last;
         end
         QUAD_3: begin
            cos_in = y_last;
            sin_in = -x_last;
         end
         default: begin
            cos_in = x_last;
            sin_in = y_last;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff <= 1'b0;
      end else if (advance) begin
         qv_ff <= v_ff[CORDIC_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign out_valid = qv_ff;
   assign cos_out   = cos_ff;
   assign sin_out   = sin_ff;

endmodule

`default_nettype wire

// ===== src/rotated_rectangle_corners.sv =====
// Top level: CORDIC sine/cosine, vector scaling, rounding and saturated corner sums.
// Depends on rrc_pkg, the rrc_req_if / rrc_rsp_if interfaces and rrc_cordic.
`timescale 1ns / 1ps
`default_nettype none

// Computes the four corners of a rotated rectangle from its center, half extents and a
// binary angle. The datapath is a single pipeline that accepts one item every cycle while
// the output is not stalled; an item passes through one register per CORDIC iteration,
// one for the quadrant fold, one for the four multipliers, one for rounding and one output
// register for the saturated corner sums. When the response side stalls with a result
// waiting, the whole pipeline holds and req_port.ready drops in the same cycle; the
// pipeline moves whenever the output is free.
module rotated_rectangle_corners
   import rrc_pkg::*;
#(
   parameter int COORD_BITS    = 16,
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   rrc_req_if.sink   req_port,
   rrc_rsp_if.source rsp_port
);

   localparam int HALF_BITS  = COORD_BITS - 2;
   localparam int PROD_BITS  = XY_BITS + COORD_BITS - 1;
   localparam int SUM_BITS   = COORD_BITS + 2;
   localparam int CORDIC_LAT = CORDIC_STAGES + 1;

   localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (XY_FRAC - 1);
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic        [HALF_BITS-1:0]  hw;
      logic        [HALF_BITS-1:0]  hh;
   } side_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
   } center_type;

   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [SUM_BITS-1:0] s
   );
      logic signed [COORD_BITS-1:0] r;
      if (s > SUM_BITS'(COORD_MAX)) begin
         r = COORD_MAX;
      end else if (s < SUM_BITS'(COORD_MIN)) begin
         r = COORD_MIN;
      end else begin
         r = s[COORD_BITS-1:0];
      end
      return r;
   endfunction

   // Whole pipeline moves unless a finished item waits at the output
   logic advance;
   logic out_valid_ff;

   assign advance        = !out_valid_ff || rsp_port.ready;
   assign req_port.ready = advance;

   // Sine and cosine
   logic                      cord_valid;
   logic signed [XY_BITS-1:0] cord_cos, cord_sin;

   rrc_cordic #(
      .ANGLE_BITS    (ANGLE_BITS),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_port.valid),
      .angle     (req_port.angle),
      .out_valid (cord_valid),
      .cos_out   (cord_cos),
      .sin_out   (cord_sin)
   );

   // Carry center and half extents alongside the CORDIC
   side_type side_ff [CORDIC_LAT];

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= '{cx: req_port.center_x, cy: req_port.center_y,
                         hw: req_port.half_width, hh: req_port.half_height};
         for (int k = 1; k < CORDIC_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Scale cosine and sine by the half extents
   side_type                    side_last;
   logic signed [COORD_BITS-1:0] hw_s, hh_s;
   logic signed [PROD_BITS-1:0]  prod_cw_in, prod_sw_in, prod_sh_in, prod_ch_in;
   logic signed [PROD_BITS-1:0]  prod_cw_ff, prod_sw_ff, prod_sh_ff, prod_ch_ff;
   center_type                   mult_ctr_ff;
   logic                         mult_valid_ff;

   assign side_last  = side_ff[CORDIC_LAT-1];
   assign hw_s       = signed'({1'b0, side_last.hw, 1'b0}) >>> 1;
   assign hh_s       = signed'({1'b0, side_last.hh, 1'b0}) >>> 1;
   assign prod_cw_in = PROD_BITS'(cord_cos) * PROD_BITS'(hw_s[COORD_BITS-2:0]);
   assign prod_sw_in = PROD_BITS'(cord_sin) * PROD_BITS'(hw_s[COORD_BITS-2:0]);
   assign prod_sh_in = PROD_BITS'(cord_sin) * PROD_BITS'(hh_s[COORD_BITS-2:0]);
   assign prod_ch_in = PROD_BITS'(cord_cos) * PROD_BITS'(hh_s[COORD_BITS-2:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_valid_ff <= 1'b0;
      end else if (advance) begin
         mult_valid_ff <= cord_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_cw_ff  <= prod_cw_in;
         prod_sw_ff  <= prod_sw_in;
         prod_sh_ff  <= prod_sh_in;
         prod_ch_ff  <= prod_ch_in;
         mult_ctr_ff <= '{cx: side_last.cx, cy: side_last.cy};
      end
   end

   // Round Q2.30 products half up back to coordinate units
   logic signed [PROD_BITS-1:0]  rnd_cw, rnd_sw, rnd_sh, rnd_ch;
   logic signed [COORD_BITS-1:0] ex_ff, ey_ff, rs_ff, ny_ff;
   center_type                   rnd_ctr_ff;
   logic                         rnd_valid_ff;

   assign rnd_cw = prod_cw_ff + ROUND_HALF;
   assign rnd_sw = prod_sw_ff + ROUND_HALF;
   assign rnd_sh = prod_sh_ff + ROUND_HALF;
   assign rnd_ch = prod_ch_ff + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
      end else if (advance) begin
         rnd_valid_ff <= mult_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ex_ff      <= rnd_cw[XY_FRAC +: COORD_BITS];
         ey_ff      <= rnd_sw[XY_FRAC +: COORD_BITS];
         rs_ff      <= rnd_sh[XY_FRAC +: COORD_BITS];
         ny_ff      <= rnd_ch[XY_FRAC +: COORD_BITS];
         rnd_ctr_ff <= mult_ctr_ff;
      end
   end

   // Corner sums; the north x component is the negated sine term
   logic signed [SUM_BITS-1:0] cx_w, cy_w, ex_w, ey_w, rs_w, ny_w;
   logic signed [COORD_BITS-1:0] ne_x_ff, ne_y_ff, nw_x_ff, nw_y_ff;
   logic signed [COORD_BITS-1:0] sw_x_ff, sw_y_ff, se_x_ff, se_y_ff;

   assign cx_w = SUM_BITS'(rnd_ctr_ff.cx);
   assign cy_w = SUM_BITS'(rnd_ctr_ff.cy);
   assign ex_w = SUM_BITS'(ex_ff);
   assign ey_w = SUM_BITS'(ey_ff);
   assign rs_w = SUM_BITS'(rs_ff);
   assign ny_w = SUM_BITS'(ny_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= rnd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ne_x_ff <= sat_coord(cx_w + ex_w - rs_w);
         ne_y_ff <= sat_coord(cy_w + ey_w + ny_w);
         nw_x_ff <= sat_coord(cx_w - ex_w - rs_w);
         nw_y_ff <= sat_coord(cy_w - ey_w + ny_w);
         sw_x_ff <= sat_coord(cx_w - ex_w + rs_w);
         sw_y_ff <= sat_coord(cy_w - ey_w - ny_w);
         se_x_ff <= sat_coord(cx_w + ex_w + rs_w);
         se_y_ff <= sat_coord(cy_w + ey_w - ny_w);
      end
   end

   assign rsp_port.valid = out_valid_ff;
   assign rsp_port.ne_x  = ne_x_ff;
   assign rsp_port.ne_y  = ne_y_ff;
   assign rsp_port.nw_x  = nw_x_ff;
   assign rsp_port.nw_y  = nw_y_ff;
   assign rsp_port.sw_x  = sw_x_ff;
   assign rsp_port.sw_y  = sw_y_ff;
   assign rsp_port.se_x  = se_x_ff;
   assign rsp_port.se_y  = se_y_ff;

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_port.valid)
      else $error("response valid after reset");

   // A waiting result blocks intake
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && !rsp_port.ready |-> !req_port.ready)
      else $error("request taken while a result is stalled");

   // Multiplier stage takes exactly what the CORDIC delivers
   a_mult_follows_cordic: assert property (@(posedge clock) disable iff (reset)
      advance |=> mult_valid_ff == $past(cord_valid))
      else $error("valid lost or invented between CORDIC and multipliers");

   // A stall holds the stage valids in place
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(rnd_valid_ff) && $stable(mult_valid_ff))
      else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
